@@ src/sm3_compression_top_assert.svh @@
// Assertion macros for the checker file of the SM3 compression block.
`ifndef SM3_COMPRESSION_TOP_ASSERT_SVH
`define SM3_COMPRESSION_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define SM3_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sm3 check failed: always");

// An implication: when trig holds, resp must hold in the next cycle.
`define SM3_ASSERT_NEXT(lbl, trig, resp) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (resp)) \
    else $error("sm3 check failed: next cycle");

`endif

@@ src/sm3_pkg.sv @@
package sm3_pkg;

  localparam int WordW    = 32;
  localparam int BlockLen = 16;
  localparam int Rounds   = 64;

  // Working or chaining words, index 0 is A.
  typedef logic [7:0][WordW-1:0] sm3_words_t;

  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             restart_chain;
  } sm3_in_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [2:0]       word_index;
    logic             last_word;
  } sm3_out_t;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_COMPRESS,
    ST_EMIT
  } sm3_state_t;

  typedef struct packed {
    logic load;
    logic expand;
  } sm3_sched_ctrl_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] idx;
  } sm3_round_ctrl_t;

  localparam sm3_words_t SM3_IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  localparam logic [WordW-1:0] T_LOW  = 32'h79CC4519;
  localparam logic [WordW-1:0] T_HIGH = 32'h7A879D8A;

  function automatic logic [WordW-1:0] rol32(input logic [WordW-1:0] x,
                                             input logic [4:0] n);
    logic [5:0] rn;
    rn = 6'd32 - {1'b0, n};
    return (x << n) | (x >> rn);
  endfunction

  function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
    return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
  endfunction

  function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
    return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
  endfunction

  // Round constant rotated by the round number modulo 32.
  function automatic logic [WordW-1:0] t_rot(input logic [5:0] j);
    logic [WordW-1:0] t;
    t = (j[5:4] == 2'b00) ? T_LOW : T_HIGH;
    return rol32(t, j[4:0]);
  endfunction

endpackage

@@ src/sm3_sched.sv @@
module sm3_sched (
  input  logic                   clk,
  input  sm3_pkg::sm3_sched_ctrl_t ctrl,
  input  logic [31:0]            word_in,
  output logic [31:0]            w_cur,
  output logic [31:0]            w_ahead
);
  import sm3_pkg::*;

  // Sliding window of sixteen schedule words; entry 0 is W[j].
  logic [WordW-1:0] win_r [BlockLen];
  logic [WordW-1:0] win_nxt_word;
  logic [WordW-1:0] exp_word;

  assign exp_word = perm1(win_r[0] ^ win_r[7] ^ rol32(win_r[13], 5'd15))
                    ^ rol32(win_r[3], 5'd7) ^ win_r[10];

  assign win_nxt_word = ctrl.load ? word_in : exp_word;

  always_ff @(posedge clk) begin
    if (ctrl.load || ctrl.expand) begin
      for (int i = 0; i < BlockLen - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[BlockLen-1] <= win_nxt_word;
    end
  end

  assign w_cur   = win_r[0];
  assign w_ahead = win_r[4];

endmodule

@@ src/sm3_round.sv @@
module sm3_round (
  input  logic                     clk,
  input  sm3_pkg::sm3_round_ctrl_t ctrl,
  input  sm3_pkg::sm3_words_t      load_val,
  input  logic [31:0]              w_cur,
  input  logic [31:0]              w_ahead,
  output sm3_pkg::sm3_words_t      work_nxt
);
  import sm3_pkg::*;

  sm3_words_t       work_r;
  sm3_words_t       round_val;
  logic [WordW-1:0] a12, ss1, ss2, ffv, ggv, t1, t2;
  logic [WordW-1:0] va, vb, vc, vd, ve, vf, vg, vh;

  assign va = work_r[0];
  assign vb = work_r[1];
  assign vc = work_r[2];
  assign vd = work_r[3];
  assign ve = work_r[4];
  assign vf = work_r[5];
  assign vg = work_r[6];
  assign vh = work_r[7];

  always_comb begin
    a12 = rol32(va, 5'd12);
    ss1 = rol32(a12 + ve + t_rot(ctrl.idx), 5'd7);
    ss2 = ss1 ^ a12;
    if (ctrl.idx[5:4] == 2'b00) begin
      ffv = va ^ vb ^ vc;
      ggv = ve ^ vf ^ vg;
    end else begin
      ffv = (va & vb) | (va & vc) | (vb & vc);
      ggv = (ve & vf) | (~ve & vg);
    end
    t1 = ffv + vd + ss2 + (w_cur ^ w_ahead);
    t2 = ggv + vh + ss1 + w_cur;
    round_val[0] = t1;
    round_val[1] = va;
    round_val[2] = rol32(vb, 5'd9);
    round_val[3] = vc;
    round_val[4] = perm0(t2);
    round_val[5] = ve;
    round_val[6] = rol32(vf, 5'd19);
    round_val[7] = vg;
  end

  assign work_nxt = round_val;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work_r <= load_val;
    end else if (ctrl.step) begin
      work_r <= round_val;
    end
  end

endmodule

@@ src/sm3_compression_top.sv @@
// After the 16th word of a block is taken, the block is compressed with one shared
// round unit, one round per cycle; the first digest word is valid in the cycle
// after the last round, then one digest word per transfer. No new message word
// is taken until the eighth digest word of the block has been sent.
// Reset (rst_n low, synchronous): chaining value to the SM3 initial value,
// word count and pending restart to zero, block waits for the first word.
module sm3_compression_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sm3_pkg::sm3_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sm3_pkg::sm3_out_t out_data
);
  import sm3_pkg::*;

  // Control state of the sequencer.
  sm3_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [5:0] round_r, round_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       pend_r, pend_nxt;

  // Chaining value; it also holds the digest words while they are emitted.
  sm3_words_t cv_r;
  sm3_words_t base_val;
  sm3_words_t work_nxt;

  sm3_sched_ctrl_t sched_ctrl;
  sm3_round_ctrl_t round_ctrl;
  logic [WordW-1:0] w_cur, w_ahead;

  logic in_xfer, out_xfer, block_done, last_round;

  assign in_xfer    = in_valid && in_ready;
  assign out_xfer   = out_valid && out_ready;
  assign block_done = in_xfer && (cnt_r == 4'd15);
  assign last_round = (round_r == 6'(Rounds - 1));

  // A restart flag on any word of the block reloads the initial value
  // just before that block is compressed.
  assign base_val = (pend_r || in_data.restart_chain) ? SM3_IV : cv_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (block_done) state_nxt = ST_COMPRESS;
      end
      ST_COMPRESS: begin
        if (last_round) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer && (oidx_r == 3'd7)) state_nxt = ST_COLLECT;
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // Output and datapath control.
  always_comb begin
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    sched_ctrl.load   = 1'b0;
    sched_ctrl.expand = 1'b0;
    round_ctrl.load   = 1'b0;
    round_ctrl.step   = 1'b0;
    round_ctrl.idx    = round_r;
    cnt_nxt           = cnt_r;
    pend_nxt          = pend_r;
    round_nxt         = round_r;
    oidx_nxt          = oidx_r;
    unique case (state_r)
      ST_COLLECT: begin
        in_ready        = 1'b1;
        sched_ctrl.load = in_xfer;
        round_ctrl.load = block_done;
        if (in_xfer) begin
          cnt_nxt  = cnt_r + 4'd1;
          pend_nxt = block_done ? 1'b0 : (pend_r || in_data.restart_chain);
        end
        round_nxt = '0;
      end
      ST_COMPRESS: begin
        sched_ctrl.expand = 1'b1;
        round_ctrl.step   = 1'b1;
        round_nxt         = round_r + 6'd1;
        oidx_nxt          = '0;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_xfer) oidx_nxt = oidx_r + 3'd1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign out_data.digest_word = cv_r[oidx_r];
  assign out_data.word_index  = oidx_r;
  assign out_data.last_word   = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      cnt_r   <= '0;
      round_r <= '0;
      oidx_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      round_r <= round_nxt;
      oidx_r  <= oidx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // The chaining value is architectural state, so it is reset as well.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= SM3_IV;
    end else if (block_done) begin
      cv_r <= base_val;
    end else if ((state_r == ST_COMPRESS) && last_round) begin
      cv_r <= cv_r ^ work_nxt;
    end
  end

  sm3_sched u_sched (
    .clk     (clk),
    .ctrl    (sched_ctrl),
    .word_in (in_data.message_word),
    .w_cur   (w_cur),
    .w_ahead (w_ahead)
  );

  sm3_round u_round (
    .clk      (clk),
    .ctrl     (round_ctrl),
    .load_val (base_val),
    .w_cur    (w_cur),
    .w_ahead  (w_ahead),
    .work_nxt (work_nxt)
  );

endmodule

@@ src/sm3_checker.sv @@
`include "sm3_compression_top_assert.svh"

module sm3_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input sm3_pkg::sm3_out_t out_data
);
  import sm3_pkg::*;

  logic       out_xfer;
  logic       more_words;
  logic       idx_is_last;
  logic [2:0] idx_next;

  assign out_xfer    = out_valid && out_ready;
  assign more_words  = out_xfer && !out_data.last_word;
  assign idx_is_last = (out_data.word_index == 3'd7);
  assign idx_next    = out_data.word_index + 3'd1;

  // Words are never taken while digest words are being offered.
  `SM3_ASSERT_ALWAYS(a_no_overlap, !(out_valid && in_ready))

  // A stalled digest transfer holds its payload.
  `SM3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Digest words come in order without gaps.
  `SM3_ASSERT_NEXT(a_out_order, more_words, out_valid && (out_data.word_index == $past(idx_next)))

  // After the final digest word the block takes message words again.
  `SM3_ASSERT_NEXT(a_back_to_input, out_xfer && out_data.last_word, in_ready && !out_valid)

  // The last flag marks exactly the eighth word.
  `SM3_ASSERT_ALWAYS(a_last_flag, !out_valid || (out_data.last_word == idx_is_last))

endmodule

bind sm3_compression_top sm3_checker u_sm3_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the SM3 compression block.
//
// Message words go in through a valid/ready channel, one word per transfer.
// Every sixteenth accepted word completes a block. A bench-side model of the
// compression then works out the eight chaining words that the block must
// send back. The result channel is checked transfer by transfer against the
// oldest entry in the digest FIFO. Both channels idle at random, and one
// phase holds the result side off long enough that the block backs up into
// its input channel.
module tb_top;
  import sm3_pkg::*;

  // The receiver counts this many cycles for the long hold-off.
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed after the last expected digest word has arrived.
  localparam int TAIL_CYCLES = 120;
  // Random blocks in the main phase.
  localparam int RANDOM_BLOCKS = 8;

  // Standard initial chaining value, word 0 in the top bits.
  localparam logic [255:0] INIT_CHAIN =
    256'h7380166F_4914B2B9_172442D7_DA8A0600_A96F30BC_163138AA_E38DEE4D_B0FB0E4E;
  // Published digest of "abc", which is one padded block.
  localparam logic [255:0] ABC_DIGEST =
    256'h66C7F0F4_62EEEDD9_D1F2D46B_DC10E4E2_4167C487_5CF2F7A2_297DA02B_8F4BA8E0;
  localparam logic [31:0] ROUND_T_EARLY = 32'h79CC4519;
  localparam logic [31:0] ROUND_T_LATE  = 32'h7A879D8A;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  sm3_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  sm3_out_t out_data;

  // Bench-side copy of the block's state.
  logic [31:0] chain_state [8];
  logic [31:0] msg_block [16];
  int          fill_count = 0;
  logic        restart_pending = 1'b0;

  // Digest words still owed by the block, oldest first.
  sm3_out_t digest_fifo [$];

  int mismatches    = 0;
  int blocks_folded = 0;
  int words_checked = 0;

  // Steady modes switch off the random idling on one side. hold_request asks
  // the receiver for one long hold-off; the receiver clears it when done.
  bit sender_steady = 1'b0;
  bit sink_steady   = 1'b0;
  bit hold_request  = 1'b0;

  sm3_compression_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------
  // Compression model
  // ------------------------------------------------------------------

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} << (n % 32);
    return twice[63:32];
  endfunction

  function automatic logic [31:0] mix_p0(input logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function automatic logic [31:0] mix_p1(input logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  // Runs the full 64-round compression on msg_block and folds the result
  // into chain_state with a single XOR at the end.
  task automatic fold_block();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] tj, a12, s1, s2, fv, gv, t1, t2;
    for (int j = 0; j < 16; j++) w[j] = msg_block[j];
    for (int j = 16; j < 68; j++)
      w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
    a = chain_state[0]; b = chain_state[1]; c = chain_state[2]; d = chain_state[3];
    e = chain_state[4]; f = chain_state[5]; g = chain_state[6]; h = chain_state[7];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? ROUND_T_EARLY : ROUND_T_LATE;
      a12 = rotl(a, 12);
      s1  = rotl(a12 + e + rotl(tj, j), 7);
      s2  = s1 ^ a12;
      if (j < 16) begin
        fv = a ^ b ^ c;
        gv = e ^ f ^ g;
      end else begin
        fv = (a & b) | (a & c) | (b & c);
        gv = (e & f) | (~e & g);
      end
      t1 = fv + d + s2 + (w[j] ^ w[j+4]);
      t2 = gv + h + s1 + w[j];
      d = c; c = rotl(b, 9); b = a; a = t1;
      h = g; g = rotl(f, 19); f = e; e = mix_p0(t2);
    end
    chain_state[0] ^= a; chain_state[1] ^= b; chain_state[2] ^= c; chain_state[3] ^= d;
    chain_state[4] ^= e; chain_state[5] ^= f; chain_state[6] ^= g; chain_state[7] ^= h;
  endtask

  // Takes one accepted message word. A restart flag on any word of a block
  // reloads the initial value just before that block is compressed.
  task automatic absorb_word(input sm3_in_t item);
    sm3_out_t owed;
    restart_pending = restart_pending | item.restart_chain;
    msg_block[fill_count] = item.message_word;
    fill_count = (fill_count + 1) % 16;
    if (fill_count == 0) begin
      if (restart_pending) begin
        for (int k = 0; k < 8; k++) chain_state[k] = INIT_CHAIN[255 - 32*k -: 32];
      end
      restart_pending = 1'b0;
      fold_block();
      blocks_folded++;
      for (int k = 0; k < 8; k++) begin
        owed.digest_word = chain_state[k];
        owed.word_index  = 3'(k);
        owed.last_word   = (k == 7);
        digest_fifo.push_back(owed);
      end
    end
  endtask

  // ------------------------------------------------------------------
  // Monitors and checker
  // ------------------------------------------------------------------

  // Every input transfer feeds the model. Sampling at the clock edge sees the
  // values from before the edge, since all drivers use nonblocking updates.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1)
      absorb_word(in_data);
  end

  // Every result transfer is matched against the oldest owed digest word.
  always @(posedge clk) begin : check_digest
    sm3_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (digest_fifo.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer, expected none, got word %h index %0d last %0b",
                 $time, out_data.digest_word, out_data.word_index, out_data.last_word);
      end else begin
        want = digest_fifo.pop_front();
        words_checked++;
        if (out_data.digest_word !== want.digest_word) begin
          mismatches++;
          $display("%0t: digest_word expected %h, got %h",
                   $time, want.digest_word, out_data.digest_word);
        end
        if (out_data.word_index !== want.word_index) begin
          mismatches++;
          $display("%0t: word_index expected %0d, got %0d",
                   $time, want.word_index, out_data.word_index);
        end
        if (out_data.last_word !== want.last_word) begin
          mismatches++;
          $display("%0t: last_word expected %0b, got %0b",
                   $time, want.last_word, out_data.last_word);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Message words lean on the extremes and on single-bit patterns.
  function automatic logic [31:0] next_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // Offers one word and returns at the edge where it is taken. Valid stays
  // high on return so that a following word can go out with no gap; anything
  // that does not send next must lower it in the same step.
  task automatic send_word(input logic [31:0] word, input logic restart);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= {word, restart};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Sends one block; bit i of flags is the restart flag of word i.
  task automatic send_block(input logic [15:0][31:0] words, input logic [15:0] flags);
    for (int i = 0; i < 16; i++) send_word(words[i], flags[i]);
  endtask

  // Drops valid and waits until every owed digest word has come back. The
  // first wait lets the input monitor record the word taken at this edge.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (digest_fifo.size() != 0) @(posedge clk);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // The padded "abc" block straight after reset with no restart flag, so it
  // chains from the initial value the reset loaded. The model's own result
  // is also held against the published digest.
  task automatic test_known_answer();
    logic [15:0][31:0] words;
    words = '0;
    words[0]  = 32'h6162_6380;
    words[15] = 32'h0000_0018;
    send_block(words, 16'h0000);
    wait_drain();
    for (int k = 0; k < 8; k++) begin
      if (chain_state[k] !== ABC_DIGEST[255 - 32*k -: 32]) begin
        mismatches++;
        $display("%0t: model digest word %0d expected %h, got %h",
                 $time, k, ABC_DIGEST[255 - 32*k -: 32], chain_state[k]);
      end
    end
  endtask

  // All-zero and all-one words in turn, with the restart flag only on a word
  // in the middle of the block.
  task automatic test_extreme_words();
    logic [15:0][31:0] words;
    for (int i = 0; i < 16; i++) words[i] = (i % 2 == 0) ? 32'h0 : 32'hFFFF_FFFF;
    send_block(words, 16'h0200);
    wait_drain();
  endtask

  // Random blocks with restart on the first word, on a later word, on
  // scattered words, or not at all. Two blocks run with no idling anywhere.
  task automatic test_random_blocks();
    logic [15:0][31:0] words;
    logic [15:0]       flags;
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      for (int i = 0; i < 16; i++) words[i] = next_word();
      case ($urandom_range(0, 3))
        0: flags = 16'h0000;
        1: flags = 16'h0001;
        2: flags = 16'h0001 << $urandom_range(1, 15);
        default: for (int i = 0; i < 16; i++) flags[i] = ($urandom_range(0, 7) == 0);
      endcase
      sender_steady = (n == 2 || n == 3);
      sink_steady   = (n == 2 || n == 3);
      send_block(words, flags);
    end
    sender_steady = 1'b0;
    sink_steady   = 1'b0;
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while two blocks are offered
  // back to back, so the block has to stall its input until results drain.
  task automatic test_result_backpressure();
    logic [15:0][31:0] words;
    hold_request  = 1'b1;
    sender_steady = 1'b1;
    for (int n = 0; n < 2; n++) begin
      for (int i = 0; i < 16; i++) words[i] = $urandom;
      send_block(words, (n == 0) ? 16'h0001 : 16'h0000);
    end
    sender_steady = 1'b0;
    wait_drain();
  endtask

  // ------------------------------------------------------------------
  // Result side: random ready, a steady mode, and the long hold-off.
  // ------------------------------------------------------------------
  initial begin : sink_side
    int gap;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (sink_steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    for (int k = 0; k < 8; k++) chain_state[k] = INIT_CHAIN[255 - 32*k -: 32];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_known_answer();
    test_extreme_words();
    test_random_blocks();
    test_result_backpressure();

    // Nothing is owed any more; give the block time to show stray transfers.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Compressed %0d blocks and checked %0d digest words, including a long",
             blocks_folded, words_checked);
    $display("result hold-off and restart flags on first, later and scattered words.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/sm3_pkg.sv
src/sm3_sched.sv
src/sm3_round.sv
src/sm3_compression_top.sv
src/sm3_checker.sv
test/tb_top.sv
